// ===== hw/rtl/ccte_pkg.sv =====
// Shared constants, stage map and types of the constant heat capacity evaluator.
`default_nettype none
package ccte_pkg;

    // Fraction bits of the log2 mantissa loop and ln(2) in unsigned Q0.32.
    localparam int LOG2_FRAC = 24;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    // Quotient bits kept by the divider; anything wider saturates.
    localparam int QBITS = 33;

    // Stage map of the log path.
    localparam int LN_NORM = 1;
    localparam int LN_SQ0  = 2;
    localparam int LN_MUL  = LN_SQ0 + LOG2_FRAC;
    localparam int LN_SUB  = LN_MUL + 1;
    localparam int LN_CP   = LN_SUB + 1;
    localparam int LN_OUT  = LN_CP + 1;

    // Stage map of the enthalpy divider path.
    localparam int DV_MUL  = 1;
    localparam int DV_SUM  = 2;
    localparam int DV_ABS  = 3;
    localparam int DV_CMP  = 4;
    localparam int DV_DIV0 = 5;
    localparam int DV_OUT  = DV_DIV0 + QBITS - 1;

    // Stage 0 is the input register, the last stage is the output register.
    localparam int NSTAGE  = DV_OUT + 2;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_REF_TEMP     = 3'd0;
    localparam logic [2:0] REG_LOG_REF_TEMP = 3'd1;
    localparam logic [2:0] REG_ENTHALPY_REF = 3'd2;
    localparam logic [2:0] REG_ENTROPY_REF  = 3'd3;
    localparam logic [2:0] REG_HEAT_CAP     = 3'd4;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ZERO = 2'd1,
        ST_SAT  = 2'd2
    } status_t;

    typedef struct packed {
        logic [QBITS-1:0] quo;
        logic [31:0]      rem;
        logic [31:0]      divisor;
        logic             neg;
        logic             big;
    } div_res_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ccte_ln.sv =====
// Pipelined natural log of the temperature and the entropy term s/R.
`default_nettype none
module ccte_ln #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        clk,
    input  logic [ccte_pkg::NSTAGE-1:0] en,
    input  logic [31:0]                 temp,
    input  logic signed [31:0]          log_ref_temp,
    input  logic signed [31:0]          entropy_ref,
    input  logic signed [31:0]          heat_capacity,
    output logic signed [31:0]          s_val,
    output logic                        s_sat
);
    import ccte_pkg::*;

    localparam int RS = 32 + LOG2_FRAC - FRAC_BITS;
    localparam logic signed [63:0] HALF_LN = 64'sd1 <<< (RS - 1);
    localparam logic signed [64:0] HALF_S  = 65'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [65:0] MAXV = 66'sd2147483647;
    localparam logic signed [65:0] MINV = -66'sd2147483648;

    // Normalize: leading one to bit 31, integer log2 from its position.
    logic [4:0]        lead;
    logic [31:0]       norm;
    logic [31:0]       m1_reg;
    logic signed [6:0] e1_reg;

    always_comb
    begin
        lead = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (temp[i])
            begin
                lead = 5'(i);
            end
        end
        norm = temp << (5'd31 - lead);
    end

    always_ff @(posedge clk)
    begin
        if (en[LN_NORM])
        begin
            m1_reg <= norm;
            e1_reg <= $signed({2'b00, lead}) - 7'(FRAC_BITS);
        end
    end

    // One squaring per stage yields one fraction bit of log2.
    logic [31:0]          m_reg [LOG2_FRAC];
    logic [LOG2_FRAC-1:0] f_reg [LOG2_FRAC];
    logic signed [6:0]    e_reg [LOG2_FRAC];
    logic [31:0]          m_in  [LOG2_FRAC];
    logic [LOG2_FRAC-1:0] f_in  [LOG2_FRAC];
    logic signed [6:0]    e_in  [LOG2_FRAC];
    logic [31:0]          m_next [LOG2_FRAC];
    logic [LOG2_FRAC-1:0] f_next [LOG2_FRAC];
    logic [63:0]          sq    [LOG2_FRAC];

    always_comb
    begin
        for (int j = 0; j < LOG2_FRAC; j++)
        begin
            if (j == 0)
            begin
                m_in[j] = m1_reg;
                f_in[j] = '0;
                e_in[j] = e1_reg;
            end
            else
            begin
                m_in[j] = m_reg[j-1];
                f_in[j] = f_reg[j-1];
                e_in[j] = e_reg[j-1];
            end
            sq[j] = m_in[j] * m_in[j];
            if (sq[j][63])
            begin
                m_next[j] = sq[j][63:32];
                f_next[j] = {f_in[j][LOG2_FRAC-2:0], 1'b1};
            end
            else
            begin
                m_next[j] = sq[j][62:31];
                f_next[j] = {f_in[j][LOG2_FRAC-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < LOG2_FRAC; j++)
        begin
            if (en[LN_SQ0 + j])
            begin
                m_reg[j] <= m_next[j];
                f_reg[j] <= f_next[j];
                e_reg[j] <= e_in[j];
            end
        end
    end

    // Scale log2 by ln 2, round, subtract ln T0, multiply by cp, round, add s0.
    logic signed [30:0] l2;
    logic signed [32:0] ln2_s;
    logic signed [63:0] prod_reg;
    logic signed [63:0] ln_rnd;
    logic signed [63:0] ln_shift;
    logic signed [31:0] ln_val;
    logic signed [32:0] d_reg;
    logic signed [64:0] sp_reg;
    logic signed [64:0] sp_rnd;
    logic signed [65:0] s_sum;
    logic signed [31:0] s_next;
    logic               sat_next;

    always_comb
    begin
        l2       = $signed({e_reg[LOG2_FRAC-1][6:0], f_reg[LOG2_FRAC-1]});
        ln2_s    = $signed({1'b0, LN2_Q32});
        ln_rnd   = prod_reg + HALF_LN - $signed({63'd0, prod_reg[63]});
        ln_shift = ln_rnd >>> RS;
        ln_val   = $signed(ln_shift[31:0]);
        sp_rnd   = (sp_reg + HALF_S - $signed({64'd0, sp_reg[64]})) >>> FRAC_BITS;
        s_sum    = 66'(sp_rnd) + 66'(entropy_ref);
        sat_next = 1'b0;
        if (s_sum > MAXV)
        begin
            s_next   = 32'sh7fffffff;
            sat_next = 1'b1;
        end
        else if (s_sum < MINV)
        begin
            s_next   = $signed(32'h80000000);
            sat_next = 1'b1;
        end
        else
        begin
            s_next = $signed(s_sum[31:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[LN_MUL])
        begin
            prod_reg <= 64'(l2) * 64'(ln2_s);
        end
        if (en[LN_SUB])
        begin
            d_reg <= 33'(ln_val) - 33'(log_ref_temp);
        end
        if (en[LN_CP])
        begin
            sp_reg <= 65'(d_reg) * 65'(heat_capacity);
        end
        if (en[LN_OUT])
        begin
            s_val <= s_next;
            s_sat <= sat_next;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/ccte_div.sv =====
// Enthalpy numerator and its pipelined restoring division by the temperature.
`default_nettype none
module ccte_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        clk,
    input  logic [ccte_pkg::NSTAGE-1:0] en,
    input  logic [31:0]                 temp,
    input  logic [31:0]                 ref_temp,
    input  logic signed [47:0]          enthalpy_ref,
    input  logic signed [31:0]          heat_capacity,
    output ccte_pkg::div_res_t          res
);
    import ccte_pkg::*;

    // Magnitude width of the numerator, its signed width, and the compare width.
    localparam int NW  = (FRAC_BITS + 47 > 63) ? FRAC_BITS + 48 : 64;
    localparam int NSW = NW + 1;
    localparam int CW  = (NW > 65) ? NW : 65;

    logic signed [32:0]    diff;
    logic signed [64:0]    prod_reg;
    logic signed [NSW-1:0] n_reg;
    logic [NW-1:0]         mag_reg;
    logic                  neg3_reg;
    logic [31:0]           t1_reg;
    logic [31:0]           t2_reg;
    logic [31:0]           t3_reg;
    logic [64:0]           r4_reg;
    logic [31:0]           t4_reg;
    logic                  neg4_reg;
    logic                  big4_reg;

    assign diff = $signed({1'b0, temp}) - $signed({1'b0, ref_temp});

    always_ff @(posedge clk)
    begin
        if (en[DV_MUL])
        begin
            prod_reg <= 65'(diff) * 65'(heat_capacity);
            t1_reg   <= temp;
        end
        if (en[DV_SUM])
        begin
            n_reg  <= (NSW'(enthalpy_ref) <<< FRAC_BITS) + NSW'(prod_reg);
            t2_reg <= t1_reg;
        end
        if (en[DV_ABS])
        begin
            neg3_reg <= n_reg[NSW-1];
            mag_reg  <= n_reg[NSW-1] ? NW'(-n_reg) : NW'(n_reg);
            t3_reg   <= t2_reg;
        end
        if (en[DV_CMP])
        begin
            // A quotient of 2^33 or more saturates whatever the rounding.
            big4_reg <= CW'(mag_reg) >= CW'({t3_reg, 33'd0});
            r4_reg   <= 65'(mag_reg);
            t4_reg   <= t3_reg;
            neg4_reg <= neg3_reg;
        end
    end

    // One quotient bit per stage, most significant first.
    logic [64:0]      r_reg [QBITS];
    logic [QBITS-1:0] q_reg [QBITS];
    logic [31:0]      t_reg [QBITS];
    logic             n_pipe [QBITS];
    logic             b_pipe [QBITS];
    logic [64:0]      r_in  [QBITS];
    logic [QBITS-1:0] q_in  [QBITS];
    logic [31:0]      t_in  [QBITS];
    logic             n_in  [QBITS];
    logic             b_in  [QBITS];
    logic [64:0]      sub   [QBITS];
    logic             ge    [QBITS];

    always_comb
    begin
        for (int j = 0; j < QBITS; j++)
        begin
            if (j == 0)
            begin
                r_in[j] = r4_reg;
                q_in[j] = '0;
                t_in[j] = t4_reg;
                n_in[j] = neg4_reg;
                b_in[j] = big4_reg;
            end
            else
            begin
                r_in[j] = r_reg[j-1];
                q_in[j] = q_reg[j-1];
                t_in[j] = t_reg[j-1];
                n_in[j] = n_pipe[j-1];
                b_in[j] = b_pipe[j-1];
            end
            sub[j] = 65'(t_in[j]) << (QBITS - 1 - j);
            ge[j]  = r_in[j] >= sub[j];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < QBITS; j++)
        begin
            if (en[DV_DIV0 + j])
            begin
                r_reg[j]  <= ge[j] ? r_in[j] - sub[j] : r_in[j];
                q_reg[j]  <= {q_in[j][QBITS-2:0], ge[j]};
                t_reg[j]  <= t_in[j];
                n_pipe[j] <= n_in[j];
                b_pipe[j] <= b_in[j];
            end
        end
    end

    always_comb
    begin
        res.quo     = q_reg[QBITS-1];
        res.rem     = r_reg[QBITS-1][31:0];
        res.divisor = t_reg[QBITS-1];
        res.neg     = n_pipe[QBITS-1];
        res.big     = b_pipe[QBITS-1];
    end

endmodule
`default_nettype wire

// ===== hw/rtl/constant_cp_thermo_eval.sv =====
// Top level of the constant heat capacity species thermodynamics evaluator.
`default_nettype none
// For each temperature item (unsigned, FRAC_BITS fraction bits) the block returns
// cp/R, h/RT = (h0 + (T - T0) * cp) / T and s/R = s0 + cp * (ln T - ln T0) as
// signed 32-bit values with FRAC_BITS fraction bits, plus a status code: 0 ok,
// 1 zero temperature (all results zero), 2 a result saturated. The pipeline is
// 39 register stages deep and, while the output is not held, takes one item
// every cycle. The depth is set by the enthalpy divider, which retires one
// quotient bit per stage over 33 stages; the log path (24 squaring stages, one
// multiplier each) runs beside it and its result waits in a short delay line.
// Each stage holds its item while a later stage is full and stalled, so empty
// stages keep filling while a finished result waits on result_ready.
// Configuration sits on an APB-style port with 64-bit data at byte addresses
// 8*i; the user must write it only while the block is empty, which the block
// itself does not enforce. pready is always high.
module constant_cp_thermo_eval #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    input  logic               item_valid,
    output logic               item_ready,
    input  logic [31:0]        temperature,
    output logic               result_valid,
    input  logic               result_ready,
    output logic signed [31:0] cp_over_r,
    output logic signed [31:0] h_over_rt,
    output logic signed [31:0] s_over_r,
    output logic [1:0]         status
);
    import ccte_pkg::*;

    // Reset values are the 16-fraction-bit patterns rescaled to FRAC_BITS.
    localparam logic [63:0] T0_RST  = (64'd19539558 << FRAC_BITS) >> 16;
    localparam logic [63:0] LT0_RST = (64'd373397 << FRAC_BITS) >> 16;
    localparam int SDLY = DV_OUT - LN_OUT;
    localparam int LAST = NSTAGE - 1;

    // Configuration registers.
    logic [31:0]        ref_temp_reg;
    logic signed [31:0] log_ref_temp_reg;
    logic signed [47:0] enthalpy_ref_reg;
    logic signed [31:0] entropy_ref_reg;
    logic signed [31:0] heat_cap_reg;
    logic               cfg_wr;
    logic [2:0]         cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[5:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_temp_reg     <= T0_RST[31:0];
            log_ref_temp_reg <= $signed(LT0_RST[31:0]);
            enthalpy_ref_reg <= '0;
            entropy_ref_reg  <= '0;
            heat_cap_reg     <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_REF_TEMP:     ref_temp_reg     <= pwdata[31:0];
                REG_LOG_REF_TEMP: log_ref_temp_reg <= $signed(pwdata[31:0]);
                REG_ENTHALPY_REF: enthalpy_ref_reg <= $signed(pwdata[47:0]);
                REG_ENTROPY_REF:  entropy_ref_reg  <= $signed(pwdata[31:0]);
                REG_HEAT_CAP:     heat_cap_reg     <= $signed(pwdata[31:0]);
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_REF_TEMP:     prdata = {32'd0, ref_temp_reg};
            REG_LOG_REF_TEMP: prdata = {32'd0, log_ref_temp_reg};
            REG_ENTHALPY_REF: prdata = {16'd0, enthalpy_ref_reg};
            REG_ENTROPY_REF:  prdata = {32'd0, entropy_ref_reg};
            REG_HEAT_CAP:     prdata = {32'd0, heat_cap_reg};
            default:          prdata = '0;
        endcase
    end

    // Stage valid bits and stage enables. A stage loads when it is empty or
    // when the stage after it loads in the same cycle; the last stage loads when it is empty or result_ready is high.
    logic [NSTAGE-1:0] v_reg;
    logic [NSTAGE-1:0] en;

    always_comb
    begin
        en[LAST] = !v_reg[LAST] || result_ready;
        for (int i = LAST - 1; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign item_ready   = en[0];
    assign result_valid = v_reg[LAST];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= item_valid;
            end
            for (int i = 1; i < NSTAGE; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // Input register and the zero-temperature flag that follows the item.
    logic [31:0] t0_reg;
    logic        zero_reg [LAST];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            t0_reg      <= temperature;
            zero_reg[0] <= temperature == 32'd0;
        end
        for (int i = 1; i < LAST; i++)
        begin
            if (en[i])
            begin
                zero_reg[i] <= zero_reg[i-1];
            end
        end
    end

    // Entropy path.
    logic signed [31:0] s_val;
    logic               s_sat;

    ccte_ln #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ln (
        .clk           (clk),
        .en            (en),
        .temp          (t0_reg),
        .log_ref_temp  (log_ref_temp_reg),
        .entropy_ref   (entropy_ref_reg),
        .heat_capacity (heat_cap_reg),
        .s_val         (s_val),
        .s_sat         (s_sat)
    );

    // The entropy result waits here until the quotient of the same item is done.
    logic signed [31:0] s_dly_reg   [SDLY];
    logic               sat_dly_reg [SDLY];

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < SDLY; j++)
        begin
            if (en[LN_OUT + 1 + j])
            begin
                s_dly_reg[j]   <= (j == 0) ? s_val : s_dly_reg[j == 0 ? 0 : j-1];
                sat_dly_reg[j] <= (j == 0) ? s_sat : sat_dly_reg[j == 0 ? 0 : j-1];
            end
        end
    end

    // Enthalpy path.
    div_res_t dres;

    ccte_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk           (clk),
        .en            (en),
        .temp          (t0_reg),
        .ref_temp      (ref_temp_reg),
        .enthalpy_ref  (enthalpy_ref_reg),
        .heat_capacity (heat_cap_reg),
        .res           (dres)
    );

    // Final stage: round the quotient half away from zero, apply the sign,
    // clamp, and merge the status of both paths.
    logic [33:0]        qr;
    logic signed [31:0] h_next;
    logic               h_sat;
    status_t            st_next;

    always_comb
    begin
        qr    = 34'(dres.quo) + 34'({dres.rem, 1'b0} >= {1'b0, dres.divisor});
        h_sat = 1'b0;
        if (dres.big || (!dres.neg && qr > 34'd2147483647)
            || (dres.neg && qr > 34'd2147483648))
        begin
            h_next = dres.neg ? $signed(32'h80000000) : 32'sh7fffffff;
            h_sat  = 1'b1;
        end
        else
        begin
            h_next = dres.neg ? $signed(32'(34'd0 - qr)) : $signed(qr[31:0]);
        end
        priority if (zero_reg[LAST-1])
        begin
            st_next = ST_ZERO;
        end
        else if (h_sat || sat_dly_reg[SDLY-1])
        begin
            st_next = ST_SAT;
        end
        else
        begin
            st_next = ST_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[LAST])
        begin
            status <= st_next;
            if (zero_reg[LAST-1])
            begin
                cp_over_r <= '0;
                h_over_rt <= '0;
                s_over_r  <= '0;
            end
            else
            begin
                cp_over_r <= heat_cap_reg;
                h_over_rt <= h_next;
                s_over_r  <= s_dly_reg[SDLY-1];
            end
        end
    end

    // A stalled input means every stage is full behind a held result.
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> (result_valid && !result_ready && (&v_reg)))
        else $error("input stalled while the pipeline had room");

    // A zero-temperature result carries nothing but zeros.
    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status == ST_ZERO) |->
            (cp_over_r == 32'sd0 && h_over_rt == 32'sd0 && s_over_r == 32'sd0))
        else $error("zero temperature result is not all zero");

    // A result held by the consumer stays put.
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=>
            (result_valid && $stable(h_over_rt) && $stable(s_over_r) && $stable(status)))
        else $error("held result changed");

    // Status code three is never produced.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (status == ST_OK || status == ST_ZERO || status == ST_SAT))
        else $error("undefined status code");

endmodule
`default_nettype wire
